// ===== hdl/fhmt_pkg.sv =====
// Shared types and status codes for the mutex table with FIFO wait queues.
// No dependencies; every other file of the block imports this package.
package fhmt_pkg;

  localparam int unsigned IdW     = 4;
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED  = 2'd0,
    ST_QUEUED   = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_RELEASED = 2'd3
  } status_e;

  typedef struct packed {
    logic           rel;
    logic [IdW-1:0] mutex_id;
    logic [IdW-1:0] task_id;
  } req_t;

  typedef struct packed {
    status_e        status;
    logic           woken_valid;
    logic [IdW-1:0] woken_task;
  } res_t;

endpackage

// ===== hdl/fhmt_in_stage.sv =====
// Input register of the mutex table: holds one request word.
// Depends on fhmt_pkg for the request type.
module fhmt_in_stage import fhmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  req_t req_i,
  output logic valid_o,
  input  logic ready_i,
  output req_t req_o
);

  logic valid_q, valid_d;
  req_t req_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ===== hdl/fhmt_out_stage.sv =====
// Result register of the mutex table: holds one result word until taken.
// Depends on fhmt_pkg for the result type.
module fhmt_out_stage import fhmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  res_t res_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== hdl/fhmt_table.sv =====
// Mutex state, wait-queue links and the per-request decision logic.
// Depends on fhmt_pkg for the request, result and status types.
module fhmt_table import fhmt_pkg::*; #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned NUM_TASKS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  output res_t res_o
);

  localparam int unsigned MIW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int unsigned TIW = $clog2(NUM_TASKS);
  localparam int unsigned NW  = $clog2(NUM_TASKS + 1);
  localparam logic [NW-1:0] NoneTask = NW'(NUM_TASKS);

  logic [NUM_MUTEXES-1:0] owner_valid_q;
  logic [NUM_MUTEXES-1:0] queue_nonempty_q;
  logic [NUM_TASKS-1:0]   task_waiting_q;
  logic [TIW-1:0]         queue_head_q [NUM_MUTEXES];
  logic [TIW-1:0]         queue_tail_q [NUM_MUTEXES];
  logic [NW-1:0]          next_waiter_q [NUM_TASKS];

  logic [MIW-1:0] mi;
  logic [TIW-1:0] ti;
  logic           m_ok, t_ok;
  logic [TIW-1:0] head, tail;
  logic [NW-1:0]  head_next;

  logic           ov_we, ov_wd;
  logic           qne_we, qne_wd;
  logic           head_we, tail_we;
  logic [TIW-1:0] head_wd;
  logic           tw_we, tw_wd;
  logic [TIW-1:0] tw_idx;
  logic           link_we;
  logic           done_we;
  res_t           res;

  assign mi   = MIW'(req_i.mutex_id);
  assign ti   = TIW'(req_i.task_id);
  assign m_ok = 32'(req_i.mutex_id) < NUM_MUTEXES;
  assign t_ok = 32'(req_i.task_id) < NUM_TASKS;

  assign head      = queue_head_q[mi];
  assign tail      = queue_tail_q[mi];
  assign head_next = next_waiter_q[head];

  always_comb begin
    ov_we   = 1'b0;
    ov_wd   = 1'b0;
    qne_we  = 1'b0;
    qne_wd  = 1'b0;
    head_we = 1'b0;
    head_wd = ti;
    tail_we = 1'b0;
    tw_we   = 1'b0;
    tw_wd   = 1'b0;
    tw_idx  = ti;
    link_we = 1'b0;
    done_we = 1'b0;
    res     = '{status: ST_IGNORED, woken_valid: 1'b0, woken_task: '0};
    if (!req_i.rel) begin
      priority if (!m_ok || !t_ok) begin
        res.status = ST_IGNORED;
      end else if (!owner_valid_q[mi]) begin
        res.status = ST_GRANTED;
        ov_we      = 1'b1;
        ov_wd      = 1'b1;
      end else if (task_waiting_q[ti]) begin
        res.status = ST_IGNORED;
      end else begin
        // The new waiter becomes the tail; an empty queue also gets it as head.
        res.status = ST_QUEUED;
        tail_we    = 1'b1;
        tw_we      = 1'b1;
        tw_wd      = 1'b1;
        if (!queue_nonempty_q[mi]) begin
          head_we = 1'b1;
          qne_we  = 1'b1;
          qne_wd  = 1'b1;
        end else begin
          link_we = 1'b1;
        end
      end
    end else begin
      res.status = ST_RELEASED;
      if (m_ok) begin
        ov_we = 1'b1;
        ov_wd = 1'b0;
        if (queue_nonempty_q[mi]) begin
          // Ownership passes straight to the head waiter.
          ov_wd           = 1'b1;
          done_we         = 1'b1;
          tw_we           = 1'b1;
          tw_wd           = 1'b0;
          tw_idx          = head;
          res.woken_valid = 1'b1;
          res.woken_task  = IdW'(head);
          if (head == tail) begin
            qne_we = 1'b1;
            qne_wd = 1'b0;
          end else begin
            head_we = 1'b1;
            head_wd = TIW'(head_next);
            if (head_next >= NoneTask) begin
              qne_we = 1'b1;
              qne_wd = 1'b0;
            end
          end
        end
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_valid_q    <= '0;
      queue_nonempty_q <= '0;
      task_waiting_q   <= '0;
    end else if (fire_i) begin
      if (ov_we) begin
        owner_valid_q[mi] <= ov_wd;
      end
      if (qne_we) begin
        queue_nonempty_q[mi] <= qne_wd;
      end
      if (tw_we) begin
        task_waiting_q[tw_idx] <= tw_wd;
      end
    end
  end

  // Queue pointers and links are only read where they were written before.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      if (head_we) begin
        queue_head_q[mi] <= head_wd;
      end
      if (tail_we) begin
        queue_tail_q[mi]  <= ti;
        next_waiter_q[ti] <= NoneTask;
      end
      if (link_we) begin
        next_waiter_q[tail] <= NW'(ti);
      end
      if (done_we) begin
        next_waiter_q[head] <= NoneTask;
      end
    end
  end

`ifndef SYNTHESIS
  a_woken_only_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.woken_valid |-> req_i.rel && res.status == ST_RELEASED)
    else $error("woken task reported for a request that is not a release");

  a_queued_marks_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.status == ST_QUEUED |=> task_waiting_q[$past(ti)])
    else $error("queued task is not marked waiting");

  a_woken_clears_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.woken_valid |=> !task_waiting_q[$past(head)])
    else $error("woken task still marked waiting");

  a_woken_owns_mutex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (res.woken_valid || res.status == ST_GRANTED) |=> owner_valid_q[$past(mi)])
    else $error("mutex has no owner after grant or handoff");
`endif

endmodule

// ===== hdl/fifo_handoff_mutex_table.sv =====
// Mutex table with FIFO wait queues: one request word per cycle in, one result word
// per request out. A request passes an input register, is decided and applied to the
// flip-flop tables in the same cycle as it lands in a result register, and is held
// there until taken. Each of the two registers holds one word, so while results are
// not taken the block holds two words and then drops in_ready_o. Both sides use
// valid/ready; the block keeps accepting one word per cycle while results are taken.
module fifo_handoff_mutex_table import fhmt_pkg::*; #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned NUM_TASKS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [IdW-1:0]     mutex_id_i,
  input  logic [IdW-1:0]     task_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic               woken_valid_o,
  output logic [IdW-1:0]     woken_task_o
);

  req_t req_in, req_s;
  res_t res_s, res_out;
  logic s_valid, s_ready;

  assign req_in = '{rel: req_type_i, mutex_id: mutex_id_i, task_id: task_id_i};

  fhmt_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (req_in),
    .valid_o (s_valid),
    .ready_i (s_ready),
    .req_o   (req_s)
  );

  fhmt_table #(
    .NUM_MUTEXES (NUM_MUTEXES),
    .NUM_TASKS   (NUM_TASKS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s_valid && s_ready),
    .req_i  (req_s),
    .res_o  (res_s)
  );

  fhmt_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .ready_o (s_ready),
    .res_i   (res_s),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign status_o      = res_out.status;
  assign woken_valid_o = res_out.woken_valid;
  assign woken_task_o  = res_out.woken_task;

endmodule

// ===== sim/fifo_handoff_mutex_table_tb.sv =====
// Self-checking testbench for fifo_handoff_mutex_table: directed, random and back-pressure
// request words, checked against an in-bench model of the mutex and wait-queue tables.
// Depends on fhmt_pkg and the fifo_handoff_mutex_table RTL only.
module fifo_handoff_mutex_table_tb;
  import fhmt_pkg::*;

  localparam int unsigned NumIds     = 16;
  localparam logic [4:0]  NoneTask   = 5'd16;
  localparam int unsigned CycleLimit = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               req_type_i;
  logic [IdW-1:0]     mutex_id_i;
  logic [IdW-1:0]     task_id_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [StatusW-1:0] status_o;
  logic               woken_valid_o;
  logic [IdW-1:0]     woken_task_o;

  // Model of the tables, updated in acceptance order.
  logic           mt_own_vld  [NumIds];
  logic [IdW-1:0] mt_own_task [NumIds];
  logic           mt_q_busy   [NumIds];
  logic [IdW-1:0] mt_q_head   [NumIds];
  logic [IdW-1:0] mt_q_tail   [NumIds];
  logic [4:0]     mt_next     [NumIds];
  logic           mt_waiting  [NumIds];

  res_t        due_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold = 0;
  int unsigned burst_left = 0;

  fifo_handoff_mutex_table i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .mutex_id_i   (mutex_id_i),
    .task_id_i    (task_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .woken_valid_o(woken_valid_o),
    .woken_task_o (woken_task_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[fifo_handoff_mutex_table] ERROR");
      $finish;
    end
  end

  // Applies one request to the model tables and returns the result it must produce.
  // Ids are four bits wide and both tables hold sixteen entries, so no id is out of range.
  function automatic res_t mutex_table_step(input logic rel, input logic [IdW-1:0] m,
                                            input logic [IdW-1:0] t);
    res_t           r;
    logic [IdW-1:0] h;
    r = '0;
    if (!rel) begin
      if (!mt_own_vld[m]) begin
        mt_own_vld[m]  = 1'b1;
        mt_own_task[m] = t;
        r.status       = ST_GRANTED;
      end else if (mt_waiting[t]) begin
        r.status = ST_IGNORED;
      end else begin
        mt_next[t] = NoneTask;
        if (!mt_q_busy[m]) begin
          mt_q_head[m] = t;
          mt_q_tail[m] = t;
          mt_q_busy[m] = 1'b1;
        end else begin
          mt_next[mt_q_tail[m]] = {1'b0, t};
          mt_q_tail[m]          = t;
        end
        mt_waiting[t] = 1'b1;
        r.status      = ST_QUEUED;
      end
    end else begin
      r.status      = ST_RELEASED;
      mt_own_vld[m] = 1'b0;
      if (mt_q_busy[m]) begin
        h = mt_q_head[m];
        if (h == mt_q_tail[m]) begin
          mt_q_busy[m] = 1'b0;
        end else begin
          mt_q_head[m] = mt_next[h][IdW-1:0];
          if (mt_next[h][IdW]) mt_q_busy[m] = 1'b0;
        end
        mt_next[h]     = NoneTask;
        mt_waiting[h]  = 1'b0;
        mt_own_vld[m]  = 1'b1;
        mt_own_task[m] = h;
        r.woken_valid  = 1'b1;
        r.woken_task   = h;
      end
    end
    return r;
  endfunction

  // Offers one request word and holds it until the block takes it.
  task automatic send_req(input logic rel, input logic [IdW-1:0] m, input logic [IdW-1:0] t);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= rel;
    mutex_id_i <= m;
    task_id_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    due_results.push_back(mutex_table_step(rel, m, t));
  endtask

  task automatic idle_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      req_type_i <= 1'($urandom);
      mutex_id_i <= IdW'($urandom);
      task_id_i  <= IdW'($urandom);
    end
  endtask

  // Bursts of back-to-back words separated by short random gaps.
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle_sender($urandom_range(1, 6));
    end else begin
      burst_left--;
    end
  endtask

  // Mostly well-formed traffic on a few busy mutexes, so wait queues grow deep.
  task automatic send_random_req();
    logic           rel;
    logic [IdW-1:0] m;
    logic [IdW-1:0] t;
    m   = ($urandom_range(0, 3) != 0) ? IdW'($urandom_range(0, 3)) : IdW'($urandom);
    t   = IdW'($urandom);
    rel = ($urandom_range(0, 9) < 4);
    // Usually the owner releases, but foreign releases must be honored too.
    if (rel && mt_own_vld[m] && $urandom_range(0, 4) != 0) t = mt_own_task[m];
    send_req(rel, m, t);
  endtask

  task automatic test_grant_and_release();
    send_req(1'b0, 4'd0, 4'd0);
    send_req(1'b1, 4'd0, 4'd0);
    send_req(1'b1, 4'd15, 4'd3);
  endtask

  task automatic test_wait_queue_cases();
    send_req(1'b0, 4'd15, 4'd15);
    send_req(1'b0, 4'd15, 4'd15);  // The owner itself joins the queue.
    send_req(1'b0, 4'd15, 4'd7);
    send_req(1'b0, 4'd15, 4'd7);   // Already waiting, so it is ignored.
    send_req(1'b0, 4'd3, 4'd7);    // A free mutex is granted even to a waiting task.
    send_req(1'b0, 4'd3, 4'd15);   // Held mutex, waiting task: ignored.
    send_req(1'b1, 4'd15, 4'd2);   // A task that does not own the mutex releases it.
    send_req(1'b1, 4'd15, 4'd15);
    send_req(1'b1, 4'd15, 4'd7);
    send_req(1'b1, 4'd3, 4'd0);
  endtask

  task automatic test_full_queue();
    logic [IdW-1:0] order[NumIds];
    logic [IdW-1:0] tmp;
    int unsigned    j;
    foreach (order[i]) order[i] = IdW'(i);
    for (int i = NumIds - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      pace_sender();
      send_req(1'b0, 4'd5, order[i]);
    end
    repeat (NumIds + 1) begin
      pace_sender();
      send_req(1'b1, 4'd5, IdW'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int unsigned n);
    repeat (n) begin
      pace_sender();
      send_random_req();
    end
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // block fills up and must drop in_ready_o.
  task automatic test_backpressure();
    rx_hold = 80;
    repeat (40) send_random_req();
  endtask

  // Receiver: stretches of always-ready, random stalls and a sparse pattern.
  initial begin
    int unsigned mode;
    int unsigned stretch;
    int unsigned phase;
    out_ready_i = 1'b0;
    mode        = 0;
    stretch     = 0;
    phase       = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(5, 60);
        end
        stretch--;
        phase++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom);
          default: out_ready_i <= (phase % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word expected none actual status %0d woken %0d/%0d",
                 $time, status_o, woken_valid_o, woken_task_o);
      end else begin
        exp_res = due_results.pop_front();
        if (status_o !== exp_res.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status_o);
        end
        if (woken_valid_o !== exp_res.woken_valid) begin
          mismatches++;
          $display("%0t: woken_valid expected %0d actual %0d", $time,
                   exp_res.woken_valid, woken_valid_o);
        end
        if (woken_task_o !== exp_res.woken_task) begin
          mismatches++;
          $display("%0t: woken_task expected %0d actual %0d", $time,
                   exp_res.woken_task, woken_task_o);
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = 1'b0;
    mutex_id_i = '0;
    task_id_i  = '0;
    for (int i = 0; i < NumIds; i++) begin
      mt_own_vld[i]  = 1'b0;
      mt_own_task[i] = '0;
      mt_q_busy[i]   = 1'b0;
      mt_q_head[i]   = '0;
      mt_q_tail[i]   = '0;
      mt_next[i]     = '0;
      mt_waiting[i]  = 1'b0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_grant_and_release();
    test_wait_queue_cases();
    test_full_queue();
    test_random_traffic(500);
    test_backpressure();
    test_random_traffic(560);
    idle_sender(1);

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[fifo_handoff_mutex_table] OK");
    end else begin
      $display("[fifo_handoff_mutex_table] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fhmt_pkg.sv
hdl/fhmt_in_stage.sv
hdl/fhmt_out_stage.sv
hdl/fhmt_table.sv
hdl/fifo_handoff_mutex_table.sv
sim/fifo_handoff_mutex_table_tb.sv
